// ----- hw/rtl/dgc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the depth gradient colorizer.
package dgc_pkg;

  // Width of a depth word and of a configuration word on the ports.
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CHAN_W  = 8;

  // Full intensity of one colour channel.
  localparam logic [CHAN_W-1:0] FULL = 8'd255;

  // Reset values of the start registers.
  localparam logic [CFG_W-1:0] START_MAX_RST = 16'd0;
  localparam logic [CFG_W-1:0] START_MIN_RST = 16'hFFFF;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_MEASURE = 2'd0,
    OP_COLOR   = 2'd1,
    OP_RELOAD  = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_START_MAX = 2'd0,
    REG_START_MIN = 2'd1,
    REG_FIXED_MAX = 2'd2,
    REG_FIXED_MIN = 2'd3
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_COLOR
  } state_t;

  // Input word.
  typedef struct packed {
    logic [1:0]         op;
    logic [DEPTH_W-1:0] depth_mm;
    logic               valid_req;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic measure;
    logic reload;
    logic capture;
    logic setup;
    logic div_step;
    logic load_out;
  } dgc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip_div;
    logic div_last;
    logic out_free;
  } dgc_status_t;

endpackage

// ----- hw/rtl/dgc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the depth gradient colorizer.
module dgc_ctrl
  import dgc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_op,
  output logic        in_ready,
  input  dgc_status_t status,
  output dgc_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (op_t'(in_op))
            OP_MEASURE: cmd.measure = 1'b1;
            OP_RELOAD:  cmd.reload  = 1'b1;
            OP_COLOR: begin
              cmd.capture = 1'b1;
              state_nxt   = ST_SETUP;
            end
            OP_NONE: ;
          endcase
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = status.skip_div ? ST_COLOR : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_COLOR;
        end
      end
      ST_COLOR: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
    endcase
  end

  // Datapath updates only happen for a word that has been accepted.
  a_meas_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.measure || cmd.reload || cmd.capture) |-> (in_valid && in_ready))
    else $error("range update without an accepted word");

  // A colour word leaves setup towards the divider or the output stage.
  a_setup_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.setup |=> (state_r == ST_DIVIDE || state_r == ST_COLOR))
    else $error("setup not followed by divide or colour");

  // No new word is taken while a colour word is in flight.
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.setup || cmd.div_step) |-> !in_ready)
    else $error("input ready while a colour word is in flight");

endmodule

// ----- hw/rtl/dgc_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: configuration, depth range, radix-2 divider and colour stage.
module dgc_datapath
  import dgc_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_word_t          in_data,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  dgc_cmd_t          cmd,
  output dgc_status_t       status
);

  localparam int unsigned CNT_W = $clog2(FRAC_BITS);
  localparam int unsigned WIDE  = DEPTH_BITS + DEPTH_W;
  localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  // A 16-bit word brought to the depth width, truncated or zero extended.
  function automatic logic [DEPTH_BITS-1:0] to_depth(input logic [DEPTH_W-1:0] v);
    logic [WIDE-1:0] tmp;
    tmp = {{DEPTH_BITS{1'b0}}, v};
    return tmp[DEPTH_BITS-1:0];
  endfunction

  logic [CFG_W-1:0]      start_max_r;
  logic [CFG_W-1:0]      start_min_r;
  logic                  fixed_max_r;
  logic                  fixed_min_r;
  logic [DEPTH_BITS-1:0] range_max_r;
  logic [DEPTH_BITS-1:0] range_min_r;
  logic [DEPTH_BITS-1:0] range_max_nxt;
  logic [DEPTH_BITS-1:0] range_min_nxt;
  logic [DEPTH_BITS-1:0] z_in;
  logic [DEPTH_BITS-1:0] z_r;
  logic                  pix_ok_r;
  logic                  white_r;
  logic [DEPTH_BITS-1:0] rem_r;
  logic [DEPTH_BITS-1:0] den_r;
  logic [FRAC_BITS:0]    p_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  out_valid_r;
  out_word_t             out_data_r;

  // Configuration writes; the port never stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_max_r <= START_MAX_RST;
      start_min_r <= START_MIN_RST;
      fixed_max_r <= 1'b0;
      fixed_min_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_MAX: start_max_r <= cfg_data;
        REG_START_MIN: start_min_r <= cfg_data;
        REG_FIXED_MAX: fixed_max_r <= cfg_data[0];
        REG_FIXED_MIN: fixed_min_r <= cfg_data[0];
      endcase
    end
  end

  // Running range: widened by measure words, reloaded from the start values.
  assign z_in = to_depth(in_data.depth_mm);

  always_comb begin
    range_max_nxt = range_max_r;
    range_min_nxt = range_min_r;
    if (cmd.reload) begin
      range_max_nxt = to_depth(start_max_r);
      range_min_nxt = to_depth(start_min_r);
    end else if (cmd.measure && in_data.valid_req) begin
      if (!fixed_max_r && z_in > range_max_r) begin
        range_max_nxt = z_in;
      end
      if (!fixed_min_r && z_in < range_min_r) begin
        range_min_nxt = z_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_max_r <= to_depth(START_MAX_RST);
      range_min_r <= to_depth(START_MIN_RST);
    end else begin
      range_max_r <= range_max_nxt;
      range_min_r <= range_min_nxt;
    end
  end

  // Capture of a colour word.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      z_r      <= z_in;
      pix_ok_r <= in_data.valid_req;
    end
  end

  // Setup: signed offset and range as magnitudes, and the cases that
  // need no division (invalid pixel, zero range, zero offset, opposite
  // signs, or a quotient that saturates at one).
  logic                  num_neg;
  logic                  den_neg;
  logic [DEPTH_BITS-1:0] num_mag;
  logic [DEPTH_BITS-1:0] den_mag;
  logic                  p_is_zero;
  logic                  p_is_one;

  always_comb begin
    num_neg   = z_r < range_min_r;
    den_neg   = range_max_r < range_min_r;
    num_mag   = num_neg ? (range_min_r - z_r) : (z_r - range_min_r);
    den_mag   = den_neg ? (range_min_r - range_max_r) : (range_max_r - range_min_r);
    p_is_zero = (den_mag == '0) || (num_mag == '0) || (num_neg != den_neg);
    p_is_one  = !p_is_zero && (num_mag >= den_mag);
  end

  assign status.skip_div = !pix_ok_r || p_is_zero || p_is_one;

  // Restoring divider step: one quotient bit a cycle.
  logic [DEPTH_BITS:0] rem_dbl;
  logic                q_bit;
  logic [DEPTH_BITS:0] rem_sub;

  always_comb begin
    rem_dbl = {rem_r, 1'b0};
    q_bit   = rem_dbl >= {1'b0, den_r};
    rem_sub = q_bit ? (rem_dbl - {1'b0, den_r}) : rem_dbl;
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      white_r <= !pix_ok_r;
      rem_r   <= num_mag;
      den_r   <= den_mag;
      p_r     <= (pix_ok_r && p_is_one) ? ONE_FX : '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_sub[DEPTH_BITS-1:0];
      p_r   <= {p_r[FRAC_BITS-1:0], q_bit};
    end
  end

  // Step counter of the divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.setup) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign status.div_last = (cnt_r == CNT_W'(FRAC_BITS - 1));

  // Colour stage: segment from the top bits of 4p, t from its fraction.
  logic [2:0]              seg;
  logic [FRAC_BITS-1:0]    frac4;
  logic [FRAC_BITS+7:0]    prod;
  logic [CHAN_W-1:0]       t;
  out_word_t               color;

  always_comb begin
    seg   = p_r[FRAC_BITS:FRAC_BITS-2];
    frac4 = {p_r[FRAC_BITS-3:0], 2'b00};
    prod  = {frac4, 8'd0} - {8'd0, frac4};
    t     = prod[FRAC_BITS+7:FRAC_BITS];
    if (white_r) begin
      color = '{red: FULL, green: FULL, blue: FULL};
    end else begin
      unique case (seg)
        3'd0:    color = '{red: FULL,     green: t,        blue: '0};
        3'd1:    color = '{red: FULL - t, green: FULL,     blue: '0};
        3'd2:    color = '{red: '0,       green: FULL,     blue: t};
        3'd3:    color = '{red: '0,       green: FULL - t, blue: FULL};
        default: color = '{red: t,        green: '0,       blue: FULL};
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= color;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

  // The range moves only on a measure or reload word.
  a_range_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.measure || cmd.reload) |=> ($stable(range_min_r) && $stable(range_max_r)))
    else $error("depth range changed without a measure or reload word");

  // The partial remainder stays below the divisor throughout the division.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  // A result is never loaded over one still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  // The position never exceeds one.
  a_pos_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (p_r <= ONE_FX))
    else $error("gradient position above one");

endmodule

// ----- hw/rtl/depth_gradient_colorizer_unit.sv -----
`timescale 1ns / 1ps
// Depth gradient colorizer: top level joining controller and datapath.
//
// Input words carry an operation, a depth in millimetres and a validity
// flag. A measure word widens the running depth range and a reload word
// copies the start values into it; both are taken while idle and give
// no result. A colour word gives one RGB word: white for an invalid
// pixel, otherwise a red-yellow-green-cyan-blue gradient over the range.
// A colour word passes through setup and then, unless it needs no
// division, through the radix-2 divider that yields one quotient bit a
// cycle, before it is loaded into the result register.
// The next word is accepted in the cycle after the result is loaded,
// when the controller is back in idle; other words are taken every cycle while idle.
// Only one colour word is in flight at a time; input ready is high when
// the controller is idle. The result register holds a finished word while
// the receiver stalls, and a following word is still accepted; it waits
// before the output stage until the register is free.
// The configuration port is always ready; write it only while idle.
// Reset is synchronous: the start registers and the range return to their
// reset values and no result is pending.
module depth_gradient_colorizer_unit
  import dgc_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  dgc_cmd_t    cmd;
  dgc_status_t status;

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Sequencer.
  dgc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Range, divider and colour datapath.
  dgc_datapath #(
    .DEPTH_BITS (DEPTH_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
